/* hdl/frustum_cull_test_defines.svh */
// assertion macros shared by the frustum cull test checker
// depends on a clk and an rst signal in the module that uses them
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fct_pkg.sv */
// types, constants and codes for the frustum cull test
// no dependencies
package fct_pkg;

  localparam int NUM_PLANES      = 6;
  localparam int NUM_AXES        = 3;
  localparam int PART_W          = 16;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int NORMAL_FRAC     = 14;
  localparam int RADIUS_W        = 15;
  localparam int VERDICT_W       = 2;
  localparam int ACTION_W        = 2;
  localparam int COORD_WIDTH_DEF = 16;

  // packed low bits first: nx at the bottom, offset at the top
  typedef struct packed {
    logic signed [PART_W-1:0] off;
    logic signed [PART_W-1:0] nz;
    logic signed [PART_W-1:0] ny;
    logic signed [PART_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic pt_out;
    logic sph_out;
    logic sph_touch;
    logic box_out;
    logic box_touch;
  } flags_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_POINT  = 2'd0,
    ACT_SPHERE = 2'd1,
    ACT_BOX    = 2'd2
  } action_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } reg_idx_t;

endpackage

/* hdl/fct_cfg.sv */
// plane configuration registers of the frustum cull test
// depends on fct_pkg
module fct_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fct_pkg::CFG_W-1:0]     cfg_data,
  output fct_pkg::plane_t               planes [fct_pkg::NUM_PLANES]
);
  import fct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        planes[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (cfg_wr_en && cfg_index == CFG_IDX_W'(int'(REG_PLANE_LEFT) + p)) begin
          planes[p] <= plane_t'(cfg_data);
        end
      end
    end
  end

endmodule

/* hdl/fct_plane.sv */
// one frustum plane lane: product stage and distance compares
// depends on fct_pkg
module fct_plane #(
  parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                load,
  input  fct_pkg::plane_t                     plane,
  input  logic signed [COORD_WIDTH-1:0]       lo [fct_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]       hi [fct_pkg::NUM_AXES],
  input  logic        [fct_pkg::RADIUS_W-1:0] radius,
  output fct_pkg::flags_t                     flags
);
  import fct_pkg::*;

  localparam int PROD_W = COORD_WIDTH + PART_W;
  localparam int OFF_W  = PART_W + NORMAL_FRAC;
  localparam int DIST_W = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;

  logic signed [PART_W-1:0] nrm [NUM_AXES];
  logic signed [PROD_W-1:0] prod_lo [NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi [NUM_AXES];
  logic signed [DIST_W-1:0] off_term;
  logic signed [DIST_W-1:0] rad_term;
  logic signed [DIST_W-1:0] dist_lo;
  logic signed [DIST_W-1:0] dist_pos;
  logic signed [DIST_W-1:0] dist_neg;

  assign nrm[0] = plane.nx;
  assign nrm[1] = plane.ny;
  assign nrm[2] = plane.nz;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_lo[a] <= PROD_W'(nrm[a]) * PROD_W'(lo[a]);
        prod_hi[a] <= PROD_W'(nrm[a]) * PROD_W'(hi[a]);
      end
    end
  end

  assign off_term = DIST_W'(plane.off) <<< NORMAL_FRAC;
  assign rad_term = signed'(DIST_W'({radius, {NORMAL_FRAC{1'b0}}}));

  // positive corner takes max where the normal is non-negative
  always_comb begin
    dist_lo  = off_term;
    dist_pos = off_term;
    dist_neg = off_term;
    for (int a = 0; a < NUM_AXES; a++) begin
      dist_lo = dist_lo + DIST_W'(prod_lo[a]);
      if (nrm[a][PART_W-1]) begin
        dist_pos = dist_pos + DIST_W'(prod_lo[a]);
        dist_neg = dist_neg + DIST_W'(prod_hi[a]);
      end else begin
        dist_pos = dist_pos + DIST_W'(prod_hi[a]);
        dist_neg = dist_neg + DIST_W'(prod_lo[a]);
      end
    end
  end

  always_comb begin
    flags.pt_out    = dist_lo < 0;
    flags.sph_out   = dist_lo < -rad_term;
    flags.sph_touch = dist_lo < rad_term;
    flags.box_out   = dist_pos < 0;
    flags.box_touch = dist_neg < 0;
  end

endmodule

/* hdl/frustum_cull_test.sv */
// frustum cull test top level: input stage, six plane lanes, verdict stage
// depends on fct_pkg, fct_cfg, fct_plane
//
//   channel  | valid         | stall         | payload
//   query    | query_valid   | query_stall   | action, pos_*, far_*, radius
//   result   | result_valid  | result_stall  | verdict
//   config   | cfg_wr_en     | none          | cfg_index, cfg_data
//
// one query per cycle while query_stall is low; each result passes the input, product and verdict registers in turn
// stages: input register, product register in each plane lane, verdict register
// rst clears all valid flags and the plane registers to zero
// a stage loads whenever it is empty or the next stage loads, so bubbles close up
// query_stall rises only when all three stages are full and result_stall is high
module frustum_cull_test #(
  parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 query_valid,
  output logic                                 query_stall,
  input  logic [fct_pkg::ACTION_W-1:0]         action,
  input  logic signed [COORD_WIDTH-1:0]        pos_x,
  input  logic signed [COORD_WIDTH-1:0]        pos_y,
  input  logic signed [COORD_WIDTH-1:0]        pos_z,
  input  logic signed [COORD_WIDTH-1:0]        far_x,
  input  logic signed [COORD_WIDTH-1:0]        far_y,
  input  logic signed [COORD_WIDTH-1:0]        far_z,
  input  logic [fct_pkg::RADIUS_W-1:0]         radius,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [fct_pkg::VERDICT_W-1:0]        verdict,
  input  logic                                 cfg_wr_en,
  input  logic [fct_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fct_pkg::CFG_W-1:0]            cfg_data
);
  import fct_pkg::*;

  plane_t                     planes [NUM_PLANES];
  flags_t                     flags [NUM_PLANES];
  flags_t                     any;

  logic                       s1_valid;
  logic [ACTION_W-1:0]        s1_action;
  logic signed [COORD_WIDTH-1:0] s1_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s1_hi [NUM_AXES];
  logic [RADIUS_W-1:0]        s1_radius;

  logic                       s2_valid;
  logic [ACTION_W-1:0]        s2_action;
  logic [RADIUS_W-1:0]        s2_radius;

  logic                       adv1;
  logic                       adv2;
  logic                       adv3;
  verdict_t                   verdict_next;
  verdict_t                   verdict_reg;

  assign adv3        = !result_valid || !result_stall;
  assign adv2        = !s2_valid || adv3;
  assign adv1        = !s1_valid || adv2;
  assign query_stall = !adv1;

  fct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= query_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_action <= action;
      s1_lo[0]  <= pos_x;
      s1_lo[1]  <= pos_y;
      s1_lo[2]  <= pos_z;
      s1_hi[0]  <= far_x;
      s1_hi[1]  <= far_y;
      s1_hi[2]  <= far_z;
      s1_radius <= radius;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_action <= s1_action;
      s2_radius <= s1_radius;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fct_plane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_plane (
      .clk    (clk),
      .load   (adv2),
      .plane  (planes[p]),
      .lo     (s1_lo),
      .hi     (s1_hi),
      .radius (s2_radius),
      .flags  (flags[p])
    );
  end

  always_comb begin
    any = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      any = any | flags[p];
    end
  end

  always_comb begin
    unique case (s2_action)
      ACT_POINT: begin
        verdict_next = any.pt_out ? VERDICT_OUTSIDE : VERDICT_INSIDE;
      end
      ACT_SPHERE: begin
        if (any.sph_out) begin
          verdict_next = VERDICT_OUTSIDE;
        end else if (any.sph_touch) begin
          verdict_next = VERDICT_INTERSECT;
        end else begin
          verdict_next = VERDICT_INSIDE;
        end
      end
      ACT_BOX: begin
        if (any.box_out) begin
          verdict_next = VERDICT_OUTSIDE;
        end else if (any.box_touch) begin
          verdict_next = VERDICT_INTERSECT;
        end else begin
          verdict_next = VERDICT_INSIDE;
        end
      end
      default: begin
        verdict_next = VERDICT_OUTSIDE;
      end
    endcase
  end

  // verdict stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv3) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      verdict_reg <= verdict_next;
    end
  end

  assign verdict = verdict_reg;

endmodule

/* hdl/fct_checker.sv */
// port-level checks for the frustum cull test, bound to the top level
// depends on fct_pkg and frustum_cull_test_defines.svh
`include "frustum_cull_test_defines.svh"

module fct_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             query_valid,
  input logic                             query_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [fct_pkg::VERDICT_W-1:0]    verdict
);
  import fct_pkg::*;

  // held result keeps its value
  `FCT_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                   result_valid && $stable(verdict), "stalled result changed")

  // input backs up only behind a stalled result
  `FCT_ASSERT_SAME(a_stall_cause, query_stall, result_valid && result_stall,
                   "query stalled without a stalled result")

  // an accepted transaction reaches the output valid when result_stall stays low behind it
  `FCT_ASSERT_NEXT(a_latency,
                   (query_valid && !query_stall) ##1 !result_stall ##1 !result_stall,
                   result_valid, "result missing after acceptance")

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
  .clk          (clk),
  .rst          (rst),
  .query_valid  (query_valid),
  .query_stall  (query_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .verdict      (verdict)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench for frustum_cull_test: a directed table, then phases of random queries
// under changing plane settings, each verdict checked in order against the table or a local plane model
// depends on fct_pkg and the frustum_cull_test rtl
module testbench;
  import fct_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (CW - 1));
  localparam int RAD_MAX     = (1 << RADIUS_W) - 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_ROWS    = 12;
  localparam longint NORMAL_SCALE = longint'(1) << NORMAL_FRAC;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [RADIUS_W-1:0] rad_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    coord_t              px;
    coord_t              py;
    coord_t              pz;
    coord_t              fx;
    coord_t              fy;
    coord_t              fz;
    rad_t                rad;
    logic                known;
    verdict_t            want;
  } query_t;

  logic                  clk;
  logic                  rst;
  logic                  query_valid;
  logic                  query_stall;
  logic [ACTION_W-1:0]   action;
  coord_t                pos_x;
  coord_t                pos_y;
  coord_t                pos_z;
  coord_t                far_x;
  coord_t                far_y;
  coord_t                far_z;
  rad_t                  radius;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [VERDICT_W-1:0]  verdict;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  logic                  want_known;
  verdict_t              want_verdict;

  plane_t                frustum_regs [NUM_PLANES];
  logic [CFG_W-1:0]      staged_planes [NUM_PLANES];
  query_t                directed_rows [NUM_ROWS];
  verdict_t              pending_verdicts [$];
  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  bit                    calm = 1'b0;

  frustum_cull_test dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic coord_t to_coord(int v);
    if (v > COORD_MAX) v = COORD_MAX;
    else if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic longint plane_dist(plane_t pl, longint x, longint y, longint z);
    return longint'($signed(pl.nx)) * x + longint'($signed(pl.ny)) * y
         + longint'($signed(pl.nz)) * z + longint'($signed(pl.off)) * NORMAL_SCALE;
  endfunction

  function automatic verdict_t cull_verdict(query_t q);
    longint lx, ly, lz, hx, hy, hz, r, d;
    plane_t pl;
    bit outside, touching;
    outside = 1'b0;
    touching = 1'b0;
    lx = longint'($signed(q.px));
    ly = longint'($signed(q.py));
    lz = longint'($signed(q.pz));
    hx = longint'($signed(q.fx));
    hy = longint'($signed(q.fy));
    hz = longint'($signed(q.fz));
    r = longint'(q.rad) * NORMAL_SCALE;
    for (int p = 0; p < NUM_PLANES; p++) begin
      pl = frustum_regs[p];
      case (q.act)
        ACT_POINT: begin
          if (plane_dist(pl, lx, ly, lz) < 0) outside = 1'b1;
        end
        ACT_SPHERE: begin
          d = plane_dist(pl, lx, ly, lz);
          if (d < -r) outside = 1'b1;
          else if (d < r) touching = 1'b1;
        end
        ACT_BOX: begin
          // positive corner takes the max where the normal is not negative
          if (plane_dist(pl, pl.nx[PART_W-1] ? lx : hx, pl.ny[PART_W-1] ? ly : hy,
                         pl.nz[PART_W-1] ? lz : hz) < 0) outside = 1'b1;
          if (plane_dist(pl, pl.nx[PART_W-1] ? hx : lx, pl.ny[PART_W-1] ? hy : ly,
                         pl.nz[PART_W-1] ? hz : lz) < 0) touching = 1'b1;
        end
        default: outside = 1'b1;
      endcase
    end
    if (outside) return VERDICT_OUTSIDE;
    else if (touching) return VERDICT_INTERSECT;
    else return VERDICT_INSIDE;
  endfunction

  function automatic query_t mk_row(logic [ACTION_W-1:0] act, int px, int py, int pz,
                                    int fx, int fy, int fz, int rad, verdict_t want);
    query_t q;
    q.act = act;
    q.px = to_coord(px);
    q.py = to_coord(py);
    q.pz = to_coord(pz);
    q.fx = to_coord(fx);
    q.fy = to_coord(fy);
    q.fz = to_coord(fz);
    q.rad = rad_t'(rad);
    q.known = 1'b1;
    q.want = want;
    return q;
  endfunction

  function automatic query_t random_query(int span);
    query_t q;
    int pick;
    int dir;
    pick = $urandom_range(99);
    q.act = pick < 32 ? ACT_POINT : pick < 64 ? ACT_SPHERE : pick < 95 ? ACT_BOX : ACT_UNUSED;
    q.known = 1'b0;
    q.want = VERDICT_INSIDE;
    if ($urandom_range(99) < 20) begin
      q.px = coord_t'($urandom);
      q.py = coord_t'($urandom);
      q.pz = coord_t'($urandom);
      q.fx = coord_t'($urandom);
      q.fy = coord_t'($urandom);
      q.fz = coord_t'($urandom);
      q.rad = rad_t'($urandom);
    end else begin
      // scene-sized geometry, with the odd reversed box
      dir = ($urandom_range(99) < 8) ? -1 : 1;
      q.px = to_coord(int'($urandom_range(2 * span)) - span);
      q.py = to_coord(int'($urandom_range(2 * span)) - span);
      q.pz = to_coord(int'($urandom_range(2 * span)) - span);
      q.fx = to_coord(q.px + dir * int'($urandom_range(span)));
      q.fy = to_coord(q.py + dir * int'($urandom_range(span)));
      q.fz = to_coord(q.pz + dir * int'($urandom_range(span)));
      q.rad = rad_t'($urandom_range(span / 2));
    end
    return q;
  endfunction

  function automatic logic [CFG_W-1:0] cube_plane(int p, int half, int tilt);
    plane_t pl;
    int t;
    t = int'($urandom_range(2 * tilt)) - tilt;
    pl.nx = t[PART_W-1:0];
    t = int'($urandom_range(2 * tilt)) - tilt;
    pl.ny = t[PART_W-1:0];
    t = int'($urandom_range(2 * tilt)) - tilt;
    pl.nz = t[PART_W-1:0];
    t = (p % 2 == 0) ? (1 << NORMAL_FRAC) : -(1 << NORMAL_FRAC);
    case (p / 2)
      0: pl.nx = t[PART_W-1:0];
      1: pl.ny = t[PART_W-1:0];
      default: pl.nz = t[PART_W-1:0];
    endcase
    pl.off = half[PART_W-1:0];
    return pl;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_query(query_t q);
    action <= q.act;
    pos_x <= q.px;
    pos_y <= q.py;
    pos_z <= q.pz;
    far_x <= q.fx;
    far_y <= q.fy;
    far_z <= q.fz;
    radius <= q.rad;
    want_known <= q.known;
    want_verdict <= q.want;
    query_valid <= 1'b1;
    @(posedge clk);
    while (query_stall) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    query_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    query_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic load_frustum();
    wait_drained();
    for (int i = 0; i < NUM_PLANES; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= staged_planes[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < 11);
  end

  // model copy of the planes, expected verdicts and the result check
  always @(posedge clk) begin : scoreboard
    query_t cur;
    verdict_t want;
    bit moved;
    moved = 1'b0;
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) frustum_regs[p] = '0;
    end else begin
      if (cfg_wr_en) begin
        moved = 1'b1;
        if (cfg_index < NUM_PLANES) frustum_regs[cfg_index] = cfg_data;
      end
      if (query_valid && !query_stall) begin
        moved = 1'b1;
        cur.act = action;
        cur.px = pos_x;
        cur.py = pos_y;
        cur.pz = pos_z;
        cur.fx = far_x;
        cur.fy = far_y;
        cur.fz = far_z;
        cur.rad = radius;
        cur.known = 1'b0;
        cur.want = VERDICT_INSIDE;
        pending_verdicts.push_back(want_known ? want_verdict : cull_verdict(cur));
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no query waiting", verdict));
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict !== want)
            report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int span;
    query_t q;
    query_valid <= 1'b0;
    action <= ACT_POINT;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    far_x <= '0;
    far_y <= '0;
    far_z <= '0;
    radius <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_PLANE_LEFT;
    cfg_data <= '0;
    want_known <= 1'b0;
    want_verdict <= VERDICT_INSIDE;
    rst <= 1'b1;

    directed_rows[0]  = mk_row(ACT_POINT, 0, 0, 0, 0, 0, 0, 0, VERDICT_INSIDE);
    directed_rows[1]  = mk_row(ACT_POINT, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX, VERDICT_INSIDE);
    directed_rows[2]  = mk_row(ACT_POINT, COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MAX, COORD_MAX, 0, VERDICT_INSIDE);
    directed_rows[3]  = mk_row(ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0, VERDICT_INSIDE);
    directed_rows[4]  = mk_row(ACT_SPHERE, 0, 0, 0, 0, 0, 0, RAD_MAX, VERDICT_INTERSECT);
    directed_rows[5]  = mk_row(ACT_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MAX, COORD_MAX, 1, VERDICT_INTERSECT);
    directed_rows[6]  = mk_row(ACT_SPHERE, 1600, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN,
                               16, VERDICT_INTERSECT);
    directed_rows[7]  = mk_row(ACT_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MAX, COORD_MAX, 0, VERDICT_INSIDE);
    directed_rows[8]  = mk_row(ACT_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MIN, COORD_MIN, COORD_MIN, 0, VERDICT_INSIDE);
    directed_rows[9]  = mk_row(ACT_BOX, -800, -800, -800, 3200, 800, 800, RAD_MAX,
                               VERDICT_INSIDE);
    directed_rows[10] = mk_row(ACT_UNUSED, 0, 0, 0, 0, 0, 0, 0, VERDICT_OUTSIDE);
    directed_rows[11] = mk_row(ACT_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX, VERDICT_OUTSIDE);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // planes still zero from reset
    for (int i = 0; i < NUM_ROWS; i++) send_query(directed_rows[i]);

    // same rows against an axis-aligned cube of half size 1600
    for (int p = 0; p < NUM_PLANES; p++) staged_planes[p] = cube_plane(p, 1600, 0);
    load_frustum();
    for (int i = 0; i < NUM_ROWS; i++) begin
      q = directed_rows[i];
      q.known = 1'b0;
      send_query(q);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      span = COORD_MAX;
      for (int p = 0; p < NUM_PLANES; p++) begin
        case (ph)
          0: staged_planes[p] = cube_plane(p, 1600, 0);
          1: staged_planes[p] = {CFG_W{1'b1}};
          2: staged_planes[p] = {4{1'b0, {(PART_W-1){1'b1}}}};
          3: staged_planes[p] = {4{1'b1, {(PART_W-1){1'b0}}}};
          4: staged_planes[p] = cube_plane(p, 8000, 3000);
          5: staged_planes[p] = {$urandom, $urandom};
          6: staged_planes[p] = cube_plane(p, 100 + int'($urandom_range(3900)), 1500);
          default: staged_planes[p] = (p < 3) ? cube_plane(p, 2400, 800) : {$urandom, $urandom};
        endcase
      end
      case (ph)
        0: span = 3200;
        4: span = 16000;
        6: span = 2 * int'($signed(staged_planes[0][CFG_W-1 -: PART_W]));
        7: span = 4000;
        default: span = COORD_MAX;
      endcase
      load_frustum();
      calm = (ph == 4);
      repeat (PHASE_ITEMS) begin
        if (!calm && $urandom_range(99) < 11) idle_gap(1);
        send_query(random_query(span));
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
